[hdl/deq_pkg.sv]
// shared types and constants of the double-ended queue engine
package deq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned POS_W  = 9;
  localparam int unsigned CNT_W  = 9;
  localparam int unsigned QDEPTH = 2;

  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_INSERT     = 3'd4;
  localparam logic [OP_W-1:0] OP_ERASE      = 3'd5;
  localparam logic [OP_W-1:0] OP_NONE       = 3'd6;

  typedef enum logic [2:0] {
    CMD_PUSH_BACK,
    CMD_PUSH_FRONT,
    CMD_POP_BACK,
    CMD_POP_FRONT,
    CMD_INSERT,
    CMD_ERASE,
    CMD_NOP
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_EMPTY,
    ST_FULL,
    ST_BAD_POS
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FILL,
    S_LOOK,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic [CNT_W-1:0]         entry_count;
    logic                     is_empty;
    status_e                  status;
  } out_item_t;

  typedef struct packed {
    cmd_e                     cmd;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } cmd_t;

endpackage

[hdl/double_ended_queue_engine_unit.sv]
// Double-ended queue of signed 32-bit words in a ring buffer of CAPACITY
// entries, one result transaction per input transaction. A two-entry command
// queue takes transactions while the back end works, so the input stalls only
// when both slots hold waiting commands. The storage has one write port and
// two registered read ports. Push, pop and no-op pass through execute,
// front/back lookup and result load. Insert moves count - position
// entries and erase count - position - 1, each moved entry being read
// and then written back. The result register holds a finished
// transaction while the back end starts the next command. No clearing pass is
// needed after reset.
module double_ended_queue_engine_unit import deq_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  deq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  deq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

[hdl/deq_front.sv]
// front end: opcode decode and a two-entry command queue
module deq_front import deq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o,
  input  logic     cmd_pop_i
);

  cmd_t       buf_q [QDEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push, pop;
  cmd_t       dec;

  always_comb begin
    dec.value    = in_item_i.value;
    dec.position = in_item_i.position;
    unique case (in_item_i.opcode)
      OP_PUSH_BACK:  dec.cmd = CMD_PUSH_BACK;
      OP_PUSH_FRONT: dec.cmd = CMD_PUSH_FRONT;
      OP_POP_BACK:   dec.cmd = CMD_POP_BACK;
      OP_POP_FRONT:  dec.cmd = CMD_POP_FRONT;
      OP_INSERT:     dec.cmd = CMD_INSERT;
      OP_ERASE:      dec.cmd = CMD_ERASE;
      OP_NONE:       dec.cmd = CMD_NOP;
      default:       dec.cmd = CMD_NOP;
    endcase
  end

  assign in_stall_o  = (fill_q == 2'(QDEPTH));
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = buf_q[rd_ptr_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= dec;
    end
  end

endmodule

[hdl/deq_back.sv]
// back end: ring buffer storage, shift sequencer and result register
module deq_back import deq_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW:0]   CAP_EXT  = (CW + 1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
  localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

  function automatic logic [AW-1:0] slot_f(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW + 1)'(base) + {1'b0, off};
    if (sum >= CAP_EXT) begin
      sum = sum - CAP_EXT;
    end
    return sum[AW-1:0];
  endfunction

  state_e                   state_q, state_d;
  logic [AW-1:0]            head_q, head_d;
  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            idx_q, idx_d;
  logic [CW-1:0]            pos_q, pos_d;
  logic                     ins_q, ins_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  status_e                  status_q, status_d;
  logic [DATA_W-1:0]        mem_q [CAPACITY];
  logic [DATA_W-1:0]        rd_a_q, rd_b_q;
  out_item_t                out_q;
  logic                     out_valid_q;

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [DATA_W-1:0]        mem_wdata;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr_a, rd_addr_b;
  logic                     cmd_pop;
  logic                     out_free, out_load;

  logic [PW-1:0]            pos_ext, cnt_ext;
  logic [CW-1:0]            pos_cw;
  logic                     full, empty;
  logic [AW-1:0]            head_dec, head_inc;
  logic                     ins_ok, ins_shift, ers_ok, ers_shift, ers_more;
  logic [CW-1:0]            rd_off, last_off;

  assign pos_ext   = PW'(cmd_i.position);
  assign cnt_ext   = PW'(count_q);
  assign pos_cw    = pos_ext[CW-1:0];
  assign full      = (count_q == CAP_CNT);
  assign empty     = (count_q == '0);
  assign head_dec  = (head_q == '0) ? LAST_IDX : head_q - AW'(1);
  assign head_inc  = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
  assign ins_ok    = (pos_ext <= cnt_ext) && !full;
  assign ins_shift = ins_ok && (pos_ext != cnt_ext);
  assign ers_ok    = !empty && (pos_ext < cnt_ext);
  assign ers_shift = ers_ok && (({1'b0, pos_cw} + (CW + 1)'(1)) < {1'b0, count_q});
  assign ers_more  = ({1'b0, idx_q} + (CW + 1)'(2)) < {1'b0, count_q};
  assign rd_off    = ins_q ? idx_q - CW'(1) : idx_q + CW'(1);
  assign last_off  = empty ? '0 : count_q - CW'(1);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign out_load  = (state_q == S_RESULT) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.cmd == CMD_INSERT && ins_ok) begin
            state_d = ins_shift ? S_SHIFT_RD : S_FILL;
          end else if (cmd_i.cmd == CMD_ERASE && ers_shift) begin
            state_d = S_SHIFT_RD;
          end else begin
            state_d = S_LOOK;
          end
        end
      end
      S_SHIFT_RD: state_d = S_SHIFT_WR;
      S_SHIFT_WR: begin
        if (ins_q) begin
          state_d = (idx_q - CW'(1) == pos_q) ? S_FILL : S_SHIFT_RD;
        end else begin
          state_d = ers_more ? S_SHIFT_RD : S_LOOK;
        end
      end
      S_FILL:   state_d = S_LOOK;
      S_LOOK:   state_d = S_RESULT;
      S_RESULT: state_d = out_free ? S_IDLE : S_RESULT;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    ins_d     = ins_q;
    val_d     = val_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_waddr = slot_f(head_q, idx_q);
    mem_wdata = rd_a_q;
    rd_en     = 1'b0;
    rd_addr_a = slot_f(head_q, rd_off);
    rd_addr_b = slot_f(head_q, last_off);
    cmd_pop   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop   = 1'b1;
          status_d  = ST_OK;
          val_d     = cmd_i.value;
          pos_d     = pos_cw;
          mem_wdata = cmd_i.value;
          unique case (cmd_i.cmd)
            CMD_PUSH_BACK: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = slot_f(head_q, count_q);
                count_d   = count_q + CW'(1);
              end
            end
            CMD_PUSH_FRONT: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = head_dec;
                head_d    = head_dec;
                count_d   = count_q + CW'(1);
              end
            end
            CMD_POP_BACK: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
              end
            end
            CMD_POP_FRONT: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                head_d  = head_inc;
                count_d = count_q - CW'(1);
              end
            end
            CMD_INSERT: begin
              if (pos_ext > cnt_ext) begin
                status_d = ST_BAD_POS;
              end else if (full) begin
                status_d = ST_FULL;
              end else begin
                ins_d = 1'b1;
                idx_d = count_q;
              end
            end
            CMD_ERASE: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else if (!ers_ok) begin
                status_d = ST_BAD_POS;
              end else begin
                ins_d = 1'b0;
                idx_d = pos_cw;
                if (!ers_shift) begin
                  count_d = count_q - CW'(1);
                end
              end
            end
            CMD_NOP: begin
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT_RD: rd_en = 1'b1;
      S_SHIFT_WR: begin
        mem_we = 1'b1;
        idx_d  = rd_off;
        if (!ins_q && !ers_more) begin
          count_d = count_q - CW'(1);
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = slot_f(head_q, pos_q);
        mem_wdata = val_q;
        count_d   = count_q + CW'(1);
      end
      S_LOOK: begin
        rd_en     = 1'b1;
        rd_addr_a = head_q;
      end
      S_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  assign cmd_pop_o = cmd_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      ins_q       <= 1'b0;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      pos_q    <= pos_d;
      ins_q    <= ins_d;
      status_q <= status_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_a_q <= mem_q[rd_addr_a];
      rd_b_q <= mem_q[rd_addr_b];
    end
    if (out_load) begin
      out_q.front_value <= empty ? '1 : rd_a_q;
      out_q.back_value  <= empty ? '1 : rd_b_q;
      out_q.entry_count <= cnt_ext[CNT_W-1:0];
      out_q.is_empty    <= empty;
      out_q.status      <= status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_CNT)
    else $error("entry count above capacity");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= LAST_IDX)
    else $error("head index outside ring");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SHIFT_RD |->
      (ins_q && idx_q != '0 && idx_q <= count_q && idx_q > pos_q) ||
      (!ins_q && ({1'b0, idx_q} + (CW + 1)'(1)) < {1'b0, count_q}))
    else $error("shift index outside stored entries");

  a_error_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOOK && status_q != ST_OK |-> $stable(count_q) && $stable(head_q))
    else $error("failed transaction changed queue state");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("loaded result not presented");

endmodule
